FILE: rtl/core/wsp_pkg.sv
// Shared widths, constants and types of the world-to-screen projection block.
`timescale 1ns / 1ps
`default_nettype none
package wsp_pkg;

  // Field widths
  localparam int CoordW = 32;
  localparam int AngW   = 16;
  localparam int DimW   = 14;
  localparam int OutW   = 24;

  // Camera axis coefficients, Q1.30
  localparam int CoefW   = 32;
  localparam int NumCoef = 9;
  localparam int FracQ30 = 30;

  // Focal scale, Q22.8, limited to +-2^28
  localparam int FocalW = 30;

  // Point pipeline widths
  localparam int DeltaW   = CoordW + 1;
  localparam int TermW    = 34;
  localparam int SumW     = 35;
  localparam int NumW     = SumW + FocalW;
  localparam int MagW     = 63;
  localparam int DivSteps = 26;
  localparam int RemW     = SumW;

  // Start cycle to result strobe: five front stages, the divide chain, one output stage
  localparam int PipeLat = 6 + DivSteps;

  // Register indexes
  localparam logic [2:0] RegCamX   = 3'd0;
  localparam logic [2:0] RegCamY   = 3'd1;
  localparam logic [2:0] RegCamZ   = 3'd2;
  localparam logic [2:0] RegPitch  = 3'd3;
  localparam logic [2:0] RegYaw    = 3'd4;
  localparam logic [2:0] RegFov    = 3'd5;
  localparam logic [2:0] RegWidth  = 3'd6;
  localparam logic [2:0] RegHeight = 3'd7;

  // Reset values
  localparam logic [15:0]     FovReset    = 16'd23040;
  localparam logic [DimW-1:0] WidthReset  = 14'd1920;
  localparam logic [DimW-1:0] HeightReset = 14'd1080;

  typedef logic signed [CoefW-1:0] coef_t;

  // Camera settings the axis derivation depends on
  typedef struct packed {
    logic [AngW-1:0] pitch;
    logic [AngW-1:0] yaw;
    logic [15:0]     fov;
    logic [DimW-1:0] width;
  } cam_cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/world_to_screen_projection_top.sv
// Top level of the world-to-screen projection: configuration, point pipeline, result strobe.
// Throughput: one point per cycle while busy is low; every stage, the 26-stage divide chain too,
// takes a new beat. After reset and after every configuration write, busy is high while the
// axis sequencer derives the axes and focal scale (the focal divide is skipped when the
// half-angle sine is not positive).
// Reset is asynchronous, active low; results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none
module world_to_screen_projection_top import wsp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CoordW-1:0] world_x_i,
  input  logic signed [CoordW-1:0] world_y_i,
  input  logic signed [CoordW-1:0] world_z_i,
  input  logic                     relative_mode_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [2:0]               cfg_index_i,
  input  logic [31:0]              cfg_data_i,
  output logic                     result_valid_o,
  output logic signed [OutW-1:0]   screen_x_o,
  output logic signed [OutW-1:0]   screen_y_o,
  output logic                     on_screen_o
);

  localparam logic signed [29:0] OutMax = 30'sd8388607;
  localparam logic signed [29:0] OutMin = -30'sd8388608;

  logic signed [CoordW-1:0] cam_x_q, cam_y_q, cam_z_q;
  logic [AngW-1:0]          pitch_q, yaw_q;
  logic [15:0]              fov_q;
  logic [DimW-1:0]          width_q, height_q;

  logic                     cfg_wr;
  logic                     derive_busy;
  cam_cfg_t                 cam_cfg;
  coef_t                    coef [NumCoef];
  logic signed [FocalW-1:0] focal;
  logic                     accept;

  // Configuration registers
  assign cfg_ready_o = !derive_busy;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q  <= '0;
      cam_y_q  <= '0;
      cam_z_q  <= '0;
      pitch_q  <= '0;
      yaw_q    <= '0;
      fov_q    <= FovReset;
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        RegCamX:   cam_x_q  <= cfg_data_i;
        RegCamY:   cam_y_q  <= cfg_data_i;
        RegCamZ:   cam_z_q  <= cfg_data_i;
        RegPitch:  pitch_q  <= cfg_data_i[AngW-1:0];
        RegYaw:    yaw_q    <= cfg_data_i[AngW-1:0];
        RegFov:    fov_q    <= cfg_data_i[15:0];
        RegWidth:  width_q  <= cfg_data_i[DimW-1:0];
        RegHeight: height_q <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  assign cam_cfg = '{pitch: pitch_q, yaw: yaw_q, fov: fov_q, width: width_q};

  wsp_derive u_derive (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_wr),
    .cfg_i   (cam_cfg),
    .busy_o  (derive_busy),
    .coef_o  (coef),
    .focal_o (focal)
  );

  assign busy   = derive_busy;
  assign accept = start && !busy;

  // Stage 1: offset from camera
  logic                     v1_q, rel1_q;
  logic signed [DeltaW-1:0] d1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    rel1_q  <= relative_mode_i;
    d1_q[0] <= DeltaW'(world_x_i) - DeltaW'(cam_x_q);
    d1_q[1] <= DeltaW'(world_y_i) - DeltaW'(cam_y_q);
    d1_q[2] <= DeltaW'(world_z_i) - DeltaW'(cam_z_q);
  end

  // Stage 2: nine dot-product terms, floored at bit 30
  logic                    v2_q, rel2_q;
  logic signed [TermW-1:0] term_q [NumCoef];

  for (genvar i = 0; i < NumCoef; i++) begin : g_term
    logic signed [DeltaW+CoefW-1:0] pt;
    assign pt = d1_q[i % 3] * coef[i];
    always_ff @(posedge clk_i) begin
      term_q[i] <= pt[FracQ30+TermW-1:FracQ30];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    rel2_q <= rel1_q;
  end

  // Stage 3: sums and depth clamp
  logic                   v3_q, rel3_q, rej3_q;
  logic signed [SumW-1:0] tx3_q, ty3_q;
  logic [SumW-1:0]        tz3_q;
  logic signed [SumW-1:0] tz_s, tx_s, ty_s;
  logic                   near;

  assign tz_s = SumW'(term_q[0]) + SumW'(term_q[1]) + SumW'(term_q[2]);
  assign tx_s = SumW'(term_q[3]) + SumW'(term_q[4]) + SumW'(term_q[5]);
  assign ty_s = SumW'(term_q[6]) + SumW'(term_q[7]) + SumW'(term_q[8]);
  assign near = tz_s < SumW'(256);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    rel3_q <= rel2_q;
    rej3_q <= rel2_q && near;
    tx3_q  <= tx_s;
    ty3_q  <= ty_s;
    tz3_q  <= near ? SumW'(256) : tz_s;
  end

  // Stage 4: scale by focal
  logic                   v4_q, rel4_q, rej4_q;
  logic [SumW-1:0]        tz4_q;
  logic signed [NumW-1:0] n4_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    rel4_q  <= rel3_q;
    rej4_q  <= rej3_q;
    tz4_q   <= tz3_q;
    n4_q[0] <= tx3_q * focal;
    n4_q[1] <= ty3_q * focal;
  end

  // Divide chain: stage 0 holds magnitude split and overflow test, then one bit a stage
  logic                vd_q   [DivSteps+1];
  logic                reld_q [DivSteps+1];
  logic                rejd_q [DivSteps+1];
  logic [SumW-1:0]     tzd_q  [DivSteps+1];
  logic [RemW-1:0]     rem_q  [2][DivSteps+1];
  logic [DivSteps-1:0] sh_q   [2][DivSteps+1];
  logic                ovf_q  [2][DivSteps+1];
  logic                sgn_q  [2][DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q[0] <= 1'b0;
    else         vd_q[0] <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    reld_q[0] <= rel4_q;
    rejd_q[0] <= rej4_q;
    tzd_q[0]  <= tz4_q;
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [NumW-1:0] nabs;
    logic [MagW-1:0]        mag;
    assign nabs = n4_q[l][NumW-1] ? -n4_q[l] : n4_q[l];
    assign mag  = nabs[MagW-1:0];

    always_ff @(posedge clk_i) begin
      sgn_q[l][0] <= n4_q[l][NumW-1];
      ovf_q[l][0] <= mag[MagW-1:DivSteps] >= {2'b0, tz4_q};
      rem_q[l][0] <= mag[DivSteps+RemW-1:DivSteps];
      sh_q[l][0]  <= mag[DivSteps-1:0];
    end

    for (genvar k = 1; k <= DivSteps; k++) begin : g_step
      logic [RemW:0] t;
      logic          ge;
      logic [RemW:0] r;
      assign t  = {rem_q[l][k-1], sh_q[l][k-1][DivSteps-1]};
      assign ge = t >= {1'b0, tzd_q[k-1]};
      assign r  = ge ? (t - {1'b0, tzd_q[k-1]}) : t;

      always_ff @(posedge clk_i) begin
        rem_q[l][k] <= r[RemW-1:0];
        sh_q[l][k]  <= {sh_q[l][k-1][DivSteps-2:0], ge};
        ovf_q[l][k] <= ovf_q[l][k-1];
        sgn_q[l][k] <= sgn_q[l][k-1];
      end
    end
  end

  for (genvar k = 1; k <= DivSteps; k++) begin : g_ctl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vd_q[k] <= 1'b0;
      else         vd_q[k] <= vd_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      reld_q[k] <= reld_q[k-1];
      rejd_q[k] <= rejd_q[k-1];
      tzd_q[k]  <= tzd_q[k-1];
    end
  end

  // Output stage: signed quotient, centering, bounds test, saturation
  logic signed [27:0] qs [2];
  logic signed [29:0] sx, sy, w8, h8;
  logic               off;

  for (genvar l = 0; l < 2; l++) begin : g_quo
    logic signed [27:0] qm;
    assign qm = $signed({2'b0, sh_q[l][DivSteps]});
    always_comb begin
      if (ovf_q[l][DivSteps]) begin
        qs[l] = sgn_q[l][DivSteps] ? -28'sd33554432 : 28'sd33554432;
      end else begin
        qs[l] = sgn_q[l][DivSteps] ? -qm : qm;
      end
    end
  end

  assign sx  = $signed({9'b0, width_q, 7'b0}) + 30'(qs[0]);
  assign sy  = $signed({9'b0, height_q, 7'b0}) - 30'(qs[1]);
  assign w8  = $signed({8'b0, width_q, 8'b0});
  assign h8  = $signed({8'b0, height_q, 8'b0});
  assign off = (reld_q[DivSteps] && sx <= 0) || sy <= 0 || sx > w8 || sy > h8;

  function automatic logic signed [OutW-1:0] sat24(input logic signed [29:0] v);
    logic signed [29:0] c;
    begin
      c = v;
      if (v > OutMax) c = OutMax;
      if (v < OutMin) c = OutMin;
      sat24 = c[OutW-1:0];
    end
  endfunction

  logic                   res_valid_q;
  logic signed [OutW-1:0] screen_x_q, screen_y_q;
  logic                   on_screen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_q <= 1'b0;
    else         res_valid_q <= vd_q[DivSteps];
  end

  always_ff @(posedge clk_i) begin
    if (rejd_q[DivSteps]) begin
      screen_x_q  <= '0;
      screen_y_q  <= '0;
      on_screen_q <= 1'b0;
    end else begin
      screen_x_q  <= sat24(sx);
      screen_y_q  <= sat24(sy);
      on_screen_q <= !off;
    end
  end

  assign result_valid_o = res_valid_q;
  assign screen_x_o     = screen_x_q;
  assign screen_y_o     = screen_y_q;
  assign on_screen_o    = on_screen_q;

  // Checks
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q)
    else $error("accepted beat did not enter the pipeline");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, PipeLat))
    else $error("result strobe without a matching accepted beat");

  a_cfg_starts_derive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> busy)
    else $error("configuration write did not start axis derivation");

endmodule
`default_nettype wire

FILE: rtl/core/wsp_derive.sv
// Camera axis and focal scale derivation: sequenced sine polynomial, products, divider.
`timescale 1ns / 1ps
`default_nettype none
module wsp_derive import wsp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  cam_cfg_t                 cfg_i,
  output logic                     busy_o,
  output coef_t                    coef_o [NumCoef],
  output logic signed [FocalW-1:0] focal_o
);

  localparam logic [2:0] StInit = 3'd0;
  localparam logic [2:0] StSin  = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StFnum = 3'd4;
  localparam logic [2:0] StFdiv = 3'd5;
  localparam logic [2:0] StIdle = 3'd6;

  localparam int DivNumW  = 52;
  localparam int DivDenW  = 31;
  localparam int DivLast  = DivNumW - 1;
  localparam int SinLast  = 6;
  localparam int NumSines = 6;
  localparam int NumMuls  = 4;

  localparam logic [AngW-1:0] QuarterTurn = 16'd16384;

  // ceil(2^32 / 45): exact quotient for every numerator below 2^21
  localparam logic [26:0] RecipDiv45 = 27'd95443718;

  localparam logic signed [33:0] SinC1 = 34'sd1686629713;
  localparam logic signed [33:0] SinC3 = 34'sd693598668;
  localparam logic signed [33:0] SinC5 = 34'sd85569306;
  localparam logic signed [33:0] SinC7 = 34'sd5026995;
  localparam logic signed [33:0] SinC9 = 34'sd172272;

  localparam logic signed [65:0] OneQ30  = 66'sd1073741824;
  localparam logic signed [65:0] HalfQ30 = 66'sd536870912;
  localparam logic [28:0]        FocalLimit = 29'd268435456;

  // Sine slots: sin p, cos p, sin y, cos y, sin h, cos h
  localparam int SinP = 0;
  localparam int CosP = 1;
  localparam int SinY = 2;
  localparam int CosY = 3;
  localparam int SinH = 4;
  localparam int CosH = 5;

  logic [2:0]            state_q, state_d;
  logic [5:0]            cnt_q, cnt_d;
  logic [2:0]            sel_q, sel_d;
  logic [30:0]           x_q;
  logic [30:0]           x2_q;
  logic signed [33:0]    acc_q;
  logic                  neg_q;
  coef_t                 sv_q [NumSines];
  coef_t                 mr_q [NumMuls];
  logic [DivNumW-1:0]    dnum_q;
  logic [DivDenW-1:0]    drem_q;
  logic [DivDenW-1:0]    dden_q;
  logic                  fneg_q;
  logic signed [FocalW-1:0] focal_q;

  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] prod;
  logic signed [65:0] prod_sh;
  logic signed [65:0] prod_rnd;
  logic signed [65:0] prod_abs;
  logic [AngW-1:0]    ang;
  logic [14:0]        rr;
  logic [DivDenW:0]   div_t;
  logic               div_ge;
  logic [DivDenW:0]   div_rem;
  logic [DivNumW-1:0] div_quo;
  logic [28:0]        focal_mag;
  coef_t              sin_m;
  logic [20:0]        h_num;
  logic [47:0]        h_prod;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StSin: begin
        case (cnt_q)
          6'd1: begin
            mul_a = $signed({3'b0, x_q});
            mul_b = $signed({1'b0, x_q});
          end
          6'd2: begin
            mul_a = SinC9;
            mul_b = $signed({1'b0, x2_q});
          end
          6'd3, 6'd4, 6'd5: begin
            mul_a = acc_q;
            mul_b = $signed({1'b0, x2_q});
          end
          6'd6: begin
            mul_a = acc_q;
            mul_b = $signed({1'b0, x_q});
          end
          default: ;
        endcase
      end
      StMul: begin
        case (sel_q)
          3'd0: begin
            mul_a = 34'(sv_q[CosP]);
            mul_b = sv_q[CosY];
          end
          3'd1: begin
            mul_a = 34'(sv_q[CosP]);
            mul_b = sv_q[SinY];
          end
          3'd2: begin
            mul_a = -34'(sv_q[SinP]);
            mul_b = sv_q[CosY];
          end
          default: begin
            mul_a = -34'(sv_q[SinP]);
            mul_b = sv_q[SinY];
          end
        endcase
      end
      StFnum: begin
        mul_a = $signed({13'b0, cfg_i.width, 7'b0});
        mul_b = sv_q[CosH];
      end
      default: ;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_sh  = prod >>> FracQ30;
  assign prod_rnd = (prod + HalfQ30) >>> FracQ30;
  assign prod_abs = prod[65] ? -prod : prod;

  // Half field of view in angle units: (fov*16 + 22) / 45 by reciprocal multiply
  assign h_num  = {1'b0, cfg_i.fov, 4'b0} + 21'd22;
  assign h_prod = 48'(h_num) * 48'(RecipDiv45);

  // Angle for the current sine slot, folded into a quarter wave
  always_comb begin
    case (sel_q)
      3'd0:    ang = cfg_i.pitch;
      3'd1:    ang = cfg_i.pitch + QuarterTurn;
      3'd2:    ang = cfg_i.yaw;
      3'd3:    ang = cfg_i.yaw + QuarterTurn;
      3'd4:    ang = dnum_q[AngW-1:0];
      default: ang = dnum_q[AngW-1:0] + QuarterTurn;
    endcase
    rr = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
  end

  // Final sine term clamped to [0, 1.0]
  always_comb begin
    if (prod_sh < 0) begin
      sin_m = '0;
    end else if (prod_sh > OneQ30) begin
      sin_m = OneQ30[CoefW-1:0];
    end else begin
      sin_m = prod_sh[CoefW-1:0];
    end
  end

  // One restoring divide step
  assign div_t   = {drem_q, dnum_q[DivNumW-1]};
  assign div_ge  = div_t >= {1'b0, dden_q};
  assign div_rem = div_ge ? (div_t - {1'b0, dden_q}) : div_t;
  assign div_quo = {dnum_q[DivNumW-2:0], div_ge};
  assign focal_mag = (div_quo > DivNumW'(FocalLimit)) ? FocalLimit : div_quo[28:0];

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    case (state_q)
      StInit: begin
        state_d = StSin;
        cnt_d   = '0;
        sel_d   = '0;
      end
      StSin: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(SinLast)) begin
          cnt_d = '0;
          if (sel_q == 3'(NumSines - 1)) begin
            state_d = StMul;
            sel_d   = '0;
          end else begin
            sel_d = sel_q + 3'd1;
          end
        end
      end
      StMul: begin
        sel_d = sel_q + 3'd1;
        if (sel_q == 3'(NumMuls - 1)) begin
          state_d = StFnum;
        end
      end
      StFnum: begin
        cnt_d = '0;
        if (sv_q[SinH][CoefW-1] || (sv_q[SinH] == '0)) begin
          state_d = StIdle;
        end else begin
          state_d = StFdiv;
        end
      end
      StFdiv: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DivLast)) begin
          state_d = StIdle;
        end
      end
      StIdle: ;
      default: state_d = StInit;
    endcase
    if (start_i) begin
      state_d = StInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      cnt_q   <= '0;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StInit: begin
        dnum_q <= DivNumW'(h_prod[47:32]);
      end
      StFdiv: begin
        dnum_q <= div_quo;
        drem_q <= div_rem[DivDenW-1:0];
        if (cnt_q == 6'(DivLast)) begin
          focal_q <= fneg_q ? -$signed({1'b0, focal_mag}) : $signed({1'b0, focal_mag});
        end
      end
      StSin: begin
        case (cnt_q)
          6'd0: begin
            x_q   <= {rr, 16'b0};
            neg_q <= ang[15];
          end
          6'd1: x2_q  <= prod_sh[30:0];
          6'd2: acc_q <= prod_sh[33:0] - SinC7;
          6'd3: acc_q <= prod_sh[33:0] + SinC5;
          6'd4: acc_q <= prod_sh[33:0] - SinC3;
          6'd5: acc_q <= prod_sh[33:0] + SinC1;
          default: sv_q[sel_q] <= neg_q ? -sin_m : sin_m;
        endcase
      end
      StMul: mr_q[sel_q[1:0]] <= prod_rnd[CoefW-1:0];
      StFnum: begin
        if (sv_q[SinH][CoefW-1] || (sv_q[SinH] == '0)) begin
          focal_q <= $signed({1'b0, FocalLimit});
        end
        dnum_q <= prod_abs[DivNumW-1:0];
        drem_q <= '0;
        dden_q <= sv_q[SinH][DivDenW-1:0];
        fneg_q <= prod[65];
      end
      default: ;
    endcase
  end

  assign busy_o  = state_q != StIdle;
  assign focal_o = focal_q;

  // Forward, right (roll free, no Z), up
  assign coef_o[0] = mr_q[0];
  assign coef_o[1] = mr_q[1];
  assign coef_o[2] = sv_q[SinP];
  assign coef_o[3] = -sv_q[SinY];
  assign coef_o[4] = sv_q[CosY];
  assign coef_o[5] = '0;
  assign coef_o[6] = mr_q[2];
  assign coef_o[7] = mr_q[3];
  assign coef_o[8] = sv_q[CosP];

endmodule
`default_nettype wire
